// ===== design/bleadv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bleadv_pkg
// Types, constants and bit-serial helpers shared by the advertising packet
// builder: word structs, queue entry, register indexes, crc and whitening.
// ----------------------------------------------------------------------------
package bleadv_pkg;

    localparam int MAX_MESSAGE_DEF = 31;

    localparam int OPQ_DEPTH = 4;
    localparam int OPQ_AW    = 2;

    localparam logic [23:0] CRC_INIT_RST = 24'h555555;
    localparam logic [23:0] CRC_POLY_RST = 24'h5A6000;
    localparam logic [47:0] ADV_ADDR_RST = 48'h0605_0403_0201;

    localparam logic [7:0]  PDU_TYPE     = 8'h02;
    localparam logic [7:0]  ADDR_HDR_LEN = 8'd6;
    localparam logic [7:0]  PAD_BYTE     = 8'h00;
    localparam logic [6:0]  WHT_SEED_BIT = 7'h40;
    localparam logic [6:0]  WHT_TAP      = 7'h04;

    localparam logic [3:0]  STEP_TYPE    = 4'd6;
    localparam logic [3:0]  STEP_LEN     = 4'd7;
    localparam logic [3:0]  STEP_ADDR0   = 4'd8;
    localparam logic [3:0]  STEP_HEAD_END = 4'd13;
    localparam logic [3:0]  STEP_PAD     = 4'd3;

    typedef enum logic [1:0] {
        CFG_CRC_INIT = 2'd0,
        CFG_CRC_POLY = 2'd1,
        CFG_ADV_ADDR = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        OP_START = 1'b0,
        OP_DATA  = 1'b1
    } t_op_kind;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEAD,
        PH_FINISH
    } t_phase;

    typedef struct packed {
        logic       cmd;
        logic [7:0] msg_length;
        logic [5:0] chan_index;
        logic [7:0] msg_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_out_word;

    typedef struct packed {
        t_op_kind   kind;
        logic       last;
        logic [7:0] length;
        logic [5:0] chan;
        logic [7:0] data;
    } t_op;

    typedef struct packed {
        logic [6:0] lfsr;
        logic [7:0] data;
    } t_wht;

    function automatic logic [7:0] head_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h00;
            3'd1:    b = 8'hAA;
            3'd2:    b = 8'hD6;
            3'd3:    b = 8'hBE;
            3'd4:    b = 8'h89;
            3'd5:    b = 8'h8E;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [23:0] crc_fold(input logic [23:0] crc,
                                             input logic [7:0]  b,
                                             input logic [23:0] poly);
        logic [23:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) begin
                c[23] = 1'b1;
                c     = c ^ poly;
            end
        end
        return c;
    endfunction

    function automatic t_wht whiten(input logic [6:0] lfsr, input logic [7:0] b);
        t_wht       res;
        logic [6:0] s;
        logic [7:0] r;
        logic       bit_o;
        s = lfsr;
        r = b;
        for (int i = 0; i < 8; i++) begin
            bit_o = s[0];
            r[i]  = r[i] ^ bit_o;
            s     = s >> 1;
            if (bit_o) begin
                s[6] = 1'b1;
                s    = s ^ WHT_TAP;
            end
        end
        res.lfsr = s;
        res.data = r;
        return res;
    endfunction

endpackage

// ===== design/bleadv_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bleadv_front
// Accepts input words, tracks the open packet and turns each word into a
// start or data operation for the op queue; stray data words are dropped.
// ----------------------------------------------------------------------------
module bleadv_front
    import bleadv_pkg::*;
#(
    parameter int MAX_MESSAGE = MAX_MESSAGE_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_word i_in_word,
    input  logic     i_q_full,
    output logic     o_full,
    output logic     o_op_push,
    output t_op      o_op
);

    logic       r_in_packet;
    logic [7:0] r_bytes_left;
    logic       n_in_packet;
    logic [7:0] n_bytes_left;
    logic       accept;
    logic [7:0] sat_len;

    assign o_full  = i_q_full;
    assign accept  = i_push && !i_q_full;
    assign sat_len = (i_in_word.msg_length > 8'(MAX_MESSAGE)) ? 8'(MAX_MESSAGE)
                                                             : i_in_word.msg_length;

    always_comb begin
        n_in_packet  = r_in_packet;
        n_bytes_left = r_bytes_left;
        o_op_push    = 1'b0;
        o_op.kind    = OP_START;
        o_op.last    = 1'b0;
        o_op.length  = sat_len;
        o_op.chan    = i_in_word.chan_index;
        o_op.data    = i_in_word.msg_byte;
        if (accept) begin
            if (i_in_word.cmd == OP_DATA) begin
                if (r_in_packet) begin
                    o_op_push    = 1'b1;
                    o_op.kind    = OP_DATA;
                    o_op.last    = (r_bytes_left == 8'd1);
                    n_bytes_left = r_bytes_left - 8'd1;
                    n_in_packet  = (r_bytes_left != 8'd1);
                end
            end else begin
                o_op_push    = 1'b1;
                o_op.kind    = OP_START;
                o_op.last    = (sat_len == 8'd0);
                n_bytes_left = sat_len;
                n_in_packet  = (sat_len != 8'd0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_packet  <= 1'b0;
            r_bytes_left <= 8'd0;
        end else begin
            r_in_packet  <= n_in_packet;
            r_bytes_left <= n_bytes_left;
        end
    end

endmodule

// ===== design/bleadv_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bleadv_queue
// Short register queue of operations between the front and the back.
// ----------------------------------------------------------------------------
module bleadv_queue
    import bleadv_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    input  logic i_pop,
    output t_op  o_op,
    output logic o_full,
    output logic o_empty
);

    t_op               r_mem [OPQ_DEPTH];
    logic [OPQ_AW-1:0] r_wr_ptr;
    logic [OPQ_AW-1:0] r_rd_ptr;
    logic [OPQ_AW:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == (OPQ_AW+1)'(OPQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_op    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== design/bleadv_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bleadv_back
// Byte sequencer: plays out header, pdu, crc and pad bytes one per cycle
// when not stalled, with crc and whitening state, config and output registers.
// ----------------------------------------------------------------------------
module bleadv_back
    import bleadv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    input  t_op         i_op,
    input  logic        i_q_empty,
    output logic        o_q_pop,
    input  logic        i_pop,
    output logic        o_empty,
    output t_out_word   o_out_word
);

    logic [23:0] r_crc_init;
    logic [23:0] r_crc_poly;
    logic [47:0] r_adv_addr;

    t_phase      r_phase,    n_phase;
    logic [3:0]  r_step,     n_step;
    logic [23:0] r_crc,      n_crc;
    logic [6:0]  r_lfsr,     n_lfsr;
    logic [7:0]  r_hdr_len,  n_hdr_len;
    logic        r_fin,      n_fin;
    logic        r_out_valid, n_out_valid;
    t_out_word   r_out_word;

    logic        adv;
    logic        emit;
    t_out_word   emit_word;
    logic [7:0]  pdu_b;
    logic [2:0]  addr_idx;
    t_wht        wht;

    assign adv        = !r_out_valid || i_pop;
    assign o_empty    = !r_out_valid;
    assign o_out_word = r_out_word;
    assign addr_idx   = 3'(r_step - STEP_ADDR0);

    always_comb begin
        n_phase   = r_phase;
        n_step    = r_step;
        n_crc     = r_crc;
        n_lfsr    = r_lfsr;
        n_hdr_len = r_hdr_len;
        n_fin     = r_fin;
        o_q_pop   = 1'b0;
        emit      = 1'b0;
        emit_word = '0;
        pdu_b     = '0;
        wht       = '0;
        case (r_phase)
            PH_IDLE: begin
                if (adv && !i_q_empty) begin
                    o_q_pop = 1'b1;
                    emit    = 1'b1;
                    if (i_op.kind == OP_START) begin
                        n_crc               = ~r_crc_init;
                        n_lfsr              = WHT_SEED_BIT | {1'b0, i_op.chan};
                        n_hdr_len           = i_op.length;
                        n_fin               = i_op.last;
                        n_step              = 4'd1;
                        n_phase             = PH_HEAD;
                        emit_word.out_byte  = head_byte(3'd0);
                    end else begin
                        wht                 = whiten(r_lfsr, i_op.data);
                        n_crc               = crc_fold(r_crc, i_op.data, r_crc_poly);
                        n_lfsr              = wht.lfsr;
                        emit_word.out_byte  = wht.data;
                        if (i_op.last) begin
                            n_phase = PH_FINISH;
                            n_step  = '0;
                        end
                    end
                end
            end
            PH_HEAD: begin
                if (adv) begin
                    emit = 1'b1;
                    if (r_step < STEP_TYPE) begin
                        emit_word.out_byte = head_byte(r_step[2:0]);
                    end else begin
                        if (r_step == STEP_TYPE) begin
                            pdu_b = PDU_TYPE;
                        end else if (r_step == STEP_LEN) begin
                            pdu_b = r_hdr_len + ADDR_HDR_LEN;
                        end else begin
                            pdu_b = r_adv_addr[8*addr_idx +: 8];
                        end
                        wht                = whiten(r_lfsr, pdu_b);
                        n_crc              = crc_fold(r_crc, pdu_b, r_crc_poly);
                        n_lfsr             = wht.lfsr;
                        emit_word.out_byte = wht.data;
                    end
                    if (r_step == STEP_HEAD_END) begin
                        n_step  = '0;
                        n_phase = r_fin ? PH_FINISH : PH_IDLE;
                    end else begin
                        n_step = r_step + 4'd1;
                    end
                end
            end
            PH_FINISH: begin
                if (adv) begin
                    emit = 1'b1;
                    if (r_step == STEP_PAD) begin
                        emit_word.out_byte  = PAD_BYTE;
                        emit_word.last_byte = 1'b1;
                        n_step              = '0;
                        n_phase             = PH_IDLE;
                    end else begin
                        wht                = whiten(r_lfsr, r_crc[8*r_step[1:0] +: 8]);
                        n_lfsr             = wht.lfsr;
                        emit_word.out_byte = wht.data;
                        n_step             = r_step + 4'd1;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_step  = '0;
            end
        endcase
        n_out_valid = emit ? 1'b1 : (i_pop ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_step      <= '0;
            r_crc       <= '0;
            r_lfsr      <= '0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
            r_crc_init  <= CRC_INIT_RST;
            r_crc_poly  <= CRC_POLY_RST;
            r_adv_addr  <= ADV_ADDR_RST;
        end else begin
            r_phase     <= n_phase;
            r_step      <= n_step;
            r_crc       <= n_crc;
            r_lfsr      <= n_lfsr;
            r_fin       <= n_fin;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CRC_INIT: r_crc_init <= i_cfg_data[23:0];
                    CFG_CRC_POLY: r_crc_poly <= i_cfg_data[23:0];
                    CFG_ADV_ADDR: r_adv_addr <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr_len <= n_hdr_len;
        if (emit) begin
            r_out_word <= emit_word;
        end
    end

    a_start_enters_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_op.kind == OP_START) |=> (r_phase == PH_HEAD && r_step == 4'd1))
        else $error("start op did not enter header phase");

    a_head_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEAD) |-> (r_step >= 4'd1 && r_step <= STEP_HEAD_END))
        else $error("header step out of range");

    a_finish_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FINISH) |-> (r_step <= STEP_PAD))
        else $error("finish step out of range");

    a_no_pop_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> !o_q_pop)
        else $error("op taken while a packet is still playing out");

    a_stalled_word_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |=> (r_out_valid && $stable(r_out_word)))
        else $error("waiting output word changed");

endmodule

// ===== design/ble_adv_packet_builder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_adv_packet_builder
// Builds a whitened BLE advertising packet with CRC-24 as a byte stream.
//
//   channel   direction  handshake             payload
//   input     in         i_push / o_full       i_in_word  (t_in_word)
//   result    out        i_pop  / o_empty      o_out_word (t_out_word)
//   config    in         i_cfg_we              i_cfg_idx, i_cfg_data
//
// one output byte per cycle from the back sequencer while the output is not
// stalled; a data word yields one byte, the last data word five bytes, a start
// word fourteen (eighteen for an empty message)
// input words are accepted every cycle while the op queue has room
// the output register reloads in the cycle it is popped
// synchronous active-low reset; config registers return to defaults
// ----------------------------------------------------------------------------
module ble_adv_packet_builder
    import bleadv_pkg::*;
#(
    parameter int MAX_MESSAGE = MAX_MESSAGE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  t_in_word    i_in_word,
    output logic        o_empty,
    input  logic        i_pop,
    output t_out_word   o_out_word,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data
);

    logic op_push;
    t_op  op_in;
    t_op  op_out;
    logic q_full;
    logic q_empty;
    logic q_pop;

    bleadv_front #(
        .MAX_MESSAGE (MAX_MESSAGE)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (i_push),
        .i_in_word (i_in_word),
        .i_q_full  (q_full),
        .o_full    (o_full),
        .o_op_push (op_push),
        .o_op      (op_in)
    );

    bleadv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (op_push),
        .i_op    (op_in),
        .i_pop   (q_pop),
        .o_op    (op_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    bleadv_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_op       (op_out),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .i_pop      (i_pop),
        .o_empty    (o_empty),
        .o_out_word (o_out_word)
    );

endmodule

// ===== dv/ble_adv_packet_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_adv_packet_checker
// Watches the input, result and register write ports of the advertising
// packet builder, predicts every packet byte from its own copy of the crc,
// whitening and packet state, and compares each popped word in order.
// ----------------------------------------------------------------------------
module ble_adv_packet_checker
    import bleadv_pkg::*;
#(
    parameter int MAX_MESSAGE = MAX_MESSAGE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  t_in_word    i_in_word,
    input  logic        i_empty,
    input  logic        i_pop,
    input  t_out_word   i_out_word,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    // pad byte, preamble and access address, low byte goes out first
    localparam logic [47:0] SYNC_SEQ         = 48'h8E89_BED6_AA00;
    localparam int          SHOWN_MISMATCHES = 10;

    logic [23:0] crc_preset;
    logic [23:0] crc_term;
    logic [47:0] adv_addr;
    logic [23:0] crc_acc;
    logic [6:0]  white_lfsr;
    logic [7:0]  left_bytes;
    logic        pkt_open;
    t_out_word   expected_bytes[$];
    int          mismatches = 0;

    function automatic void add_byte(logic [7:0] b, logic last);
        t_out_word w;
        w.out_byte  = b;
        w.last_byte = last;
        expected_bytes.push_back(w);
    endfunction

    function automatic logic [7:0] whiten_next(logic [7:0] b);
        logic [7:0] r;
        logic [6:0] s;
        logic       tap;
        r = b;
        s = white_lfsr;
        for (int i = 0; i < 8; i++) begin
            tap  = s[0];
            r[i] = r[i] ^ tap;
            s    = {1'b0, s[6:1]};
            if (tap) begin
                s = (s | WHT_SEED_BIT) ^ WHT_TAP;
            end
        end
        white_lfsr = s;
        return r;
    endfunction

    function automatic void fold_crc(logic [7:0] b);
        logic [23:0] c;
        logic        fb;
        c = crc_acc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) begin
                c[23] = 1'b1;
                c     = c ^ crc_term;
            end
        end
        crc_acc = c;
    endfunction

    function automatic void add_pdu_byte(logic [7:0] b);
        fold_crc(b);
        add_byte(whiten_next(b), 1'b0);
    endfunction

    function automatic void close_packet();
        logic [23:0] c;
        c = crc_acc;
        add_byte(whiten_next(c[7:0]), 1'b0);
        add_byte(whiten_next(c[15:8]), 1'b0);
        add_byte(whiten_next(c[23:16]), 1'b0);
        add_byte(PAD_BYTE, 1'b1);
        pkt_open   = 1'b0;
        left_bytes = '0;
    endfunction

    function automatic void predict_packet_bytes(t_in_word w);
        logic [7:0] len;
        if (w.cmd == OP_START) begin
            len = (w.msg_length > MAX_MESSAGE) ? 8'(MAX_MESSAGE) : w.msg_length;
            crc_acc    = ~crc_preset;
            white_lfsr = WHT_SEED_BIT | {1'b0, w.chan_index};
            for (int i = 0; i < 6; i++) begin
                add_byte(SYNC_SEQ[8*i +: 8], 1'b0);
            end
            add_pdu_byte(PDU_TYPE);
            add_pdu_byte(ADDR_HDR_LEN + len);
            for (int i = 0; i < 6; i++) begin
                add_pdu_byte(adv_addr[8*i +: 8]);
            end
            left_bytes = len;
            pkt_open   = 1'b1;
            if (len == 0) begin
                close_packet();
            end
        end else if (pkt_open) begin
            add_pdu_byte(w.msg_byte);
            left_bytes = left_bytes - 8'd1;
            if (left_bytes == 0) begin
                close_packet();
            end
        end
    endfunction

    // sampled mid-cycle, so handshakes are seen as they stand at the next edge
    always @(negedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            crc_preset = CRC_INIT_RST;
            crc_term   = CRC_POLY_RST;
            adv_addr   = ADV_ADDR_RST;
            crc_acc    = '0;
            white_lfsr = '0;
            left_bytes = '0;
            pkt_open   = 1'b0;
            expected_bytes.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CRC_INIT: crc_preset = i_cfg_data[23:0];
                    CFG_CRC_POLY: crc_term   = i_cfg_data[23:0];
                    CFG_ADV_ADDR: adv_addr   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_pop && !i_empty) begin
                if (expected_bytes.size() == 0) begin
                    if (mismatches < SHOWN_MISMATCHES) begin
                        $display("unexpected word: out_byte %h last_byte %b",
                                 i_out_word.out_byte, i_out_word.last_byte);
                    end
                    mismatches++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (want.out_byte !== i_out_word.out_byte ||
                        want.last_byte !== i_out_word.last_byte) begin
                        if (mismatches < SHOWN_MISMATCHES) begin
                            $display("word mismatch: out_byte exp %h got %h, last_byte exp %b got %b",
                                     want.out_byte, i_out_word.out_byte,
                                     want.last_byte, i_out_word.last_byte);
                        end
                        mismatches++;
                    end
                end
            end
            if (i_push && !i_full) begin
                predict_packet_bytes(i_in_word);
            end
        end
        o_pending    <= expected_bytes.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== dv/ble_adv_packet_builder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_adv_packet_builder_test
// Drives start and message words into the packet builder under several
// register settings, with random gaps on both sides, a long output stall
// and a final stretch at full rate; the checker predicts and compares.
// ----------------------------------------------------------------------------
module ble_adv_packet_builder_test;
    import bleadv_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS   = 70;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    t_in_word    in_word;
    logic        empty;
    logic        pop;
    t_out_word   out_word;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [47:0] cfg_data;

    int cycle_count = 0;
    int fail_count;
    int pending;
    bit sender_quiet   = 1'b0;
    bit receiver_quiet = 1'b0;
    bit calm_phase     = 1'b0;
    bit hold_request   = 1'b0;

    ble_adv_packet_builder #(
        .MAX_MESSAGE(MAX_MESSAGE_DEF)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_in_word (in_word),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_out_word(out_word),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    ble_adv_packet_checker #(
        .MAX_MESSAGE(MAX_MESSAGE_DEF)
    ) packet_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_full      (full),
        .i_in_word   (in_word),
        .i_empty     (empty),
        .i_pop       (pop),
        .i_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[ble_adv_packet_builder] ERROR");
            $finish;
        end
    end

    function automatic t_in_word make_start(logic [7:0] len, logic [5:0] chan);
        t_in_word w;
        w.cmd        = OP_START;
        w.msg_length = len;
        w.chan_index = chan;
        w.msg_byte   = 8'($urandom);
        return w;
    endfunction

    function automatic t_in_word make_data(logic [7:0] b);
        t_in_word w;
        w.cmd        = OP_DATA;
        w.msg_length = 8'($urandom);
        w.chan_index = 6'($urandom);
        w.msg_byte   = b;
        return w;
    endfunction

    // full only moves at rising edges, so it is settled mid-cycle
    task automatic send_word(input t_in_word w);
        int gap;
        if (!sender_quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push    <= 1'b1;
        in_word <= w;
        @(negedge i_clk);
        while (full) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [47:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // drain all results, then give dropped words time to leave the block
    task automatic settle();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_packets(input int items);
        int sent;
        int len;
        int eff;
        int body;
        int pick;
        sent = 0;
        while (sent < items) begin
            sender_quiet   = calm_phase || ($urandom_range(0, 5) == 0);
            receiver_quiet = sender_quiet;
            // stray word, with no packet open unless the last message was cut short
            if ($urandom_range(0, 11) == 0) begin
                send_word(make_data(8'($urandom)));
            end
            pick = $urandom_range(0, 11);
            if (pick < 7) begin
                len = $urandom_range(1, 8);
            end else if (pick == 7) begin
                len = 0;
            end else if (pick < 10) begin
                len = $urandom_range(9, MAX_MESSAGE_DEF);
            end else if (pick == 10) begin
                len = $urandom_range(MAX_MESSAGE_DEF + 1, 255);
            end else begin
                len = 255;
            end
            eff  = (len > MAX_MESSAGE_DEF) ? MAX_MESSAGE_DEF : len;
            body = eff;
            // cut the message short, the next start restarts the packet
            if (eff > 1 && $urandom_range(0, 9) == 0 && sent + 1 + eff < items) begin
                body = $urandom_range(1, eff - 1);
            end
            send_word(make_start(8'(len), 6'($urandom)));
            sent++;
            repeat (body) begin
                send_word(make_data(8'($urandom)));
                sent++;
            end
        end
    endtask

    initial begin : receiver
        int gap;
        pop = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!receiver_quiet && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 13);
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin
        push     = 1'b0;
        in_word  = '0;
        cfg_we   = 1'b0;
        cfg_idx  = CFG_CRC_INIT;
        cfg_data = '0;
        i_rst_n  = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words under reset defaults
        send_word(make_data(8'hFF));
        send_word(make_start(8'd0, 6'd0));
        send_word(make_start(8'd255, 6'd63));
        send_word(make_data(8'h00));
        send_word(make_start(8'd2, 6'h25));
        send_word(make_data(8'h00));
        send_word(make_data(8'hFF));
        send_word(make_data(8'h5A));
        send_word(make_start(8'd32, 6'h15));
        send_word(make_start(8'd0, 6'h2A));
        send_word(make_start(8'd1, 6'd63));
        send_word(make_data(8'hA5));
        send_word(make_start(8'd3, 6'h2A));
        repeat (3) send_word(make_data(8'($urandom)));
        send_packets(PHASE_ITEMS);
        settle();

        write_reg(CFG_CRC_INIT, 48'd0);
        write_reg(CFG_CRC_POLY, 48'd0);
        write_reg(CFG_ADV_ADDR, 48'd0);
        hold_request = 1'b1;
        send_packets(PHASE_ITEMS);
        settle();

        write_reg(CFG_CRC_INIT, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_CRC_POLY, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_ADV_ADDR, 48'hFFFF_FFFF_FFFF);
        send_packets(PHASE_ITEMS);
        settle();

        write_reg(CFG_CRC_INIT, 48'($urandom));
        write_reg(CFG_CRC_POLY, 48'($urandom));
        write_reg(CFG_ADV_ADDR, {16'($urandom), 32'($urandom)});
        calm_phase = 1'b1;
        send_packets(PHASE_ITEMS);
        settle();

        if (fail_count == 0 && pending == 0) begin
            $display("[ble_adv_packet_builder] OK");
        end else begin
            $display("[ble_adv_packet_builder] ERROR");
        end
        $finish;
    end

endmodule
